// ===== hdl/wplm_pkg.sv =====
// Package for the window peak level monitor.
// Holds register indexes, reset values, status codes and the register struct.
// No dependencies.
package wplm_pkg;

  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 16;
  localparam int LEVEL_BITS     = 12;
  localparam int WLEN_BITS      = 16;
  localparam int WCOUNT_BITS    = 8;
  localparam int SUM_BITS       = 20;
  localparam int STATUS_BITS    = 2;
  localparam int OUT_TDATA_BITS = 8 * ((STATUS_BITS + SUM_BITS + 7) / 8);
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_INTRUDER_LEVEL    = 8'd0,
    CFG_DISCONNECT_LEVEL  = 8'd1,
    CFG_WINDOW_LENGTH     = 8'd2,
    CFG_WINDOWS_PER_CHECK = 8'd3
  } cfg_index_t;

  localparam logic [LEVEL_BITS-1:0]  RST_INTRUDER_LEVEL    = 12'd4000;
  localparam logic [LEVEL_BITS-1:0]  RST_DISCONNECT_LEVEL  = 12'd1000;
  localparam logic [WLEN_BITS-1:0]   RST_WINDOW_LENGTH     = 16'd30000;
  localparam logic [WCOUNT_BITS-1:0] RST_WINDOWS_PER_CHECK = 8'd100;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_FINE         = 2'd0,
    STATUS_INTRUDER     = 2'd1,
    STATUS_DISCONNECTED = 2'd2
  } status_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0]  intruder_level;
    logic [LEVEL_BITS-1:0]  disconnect_level;
    logic [WLEN_BITS-1:0]   window_length;
    logic [WCOUNT_BITS-1:0] windows_per_check;
  } cfg_t;

endpackage

// ===== hdl/wplm_front.sv =====
// Front end: accepts samples, tracks the running peak and finds window ends.
// Pushes one peak per finished window into the queue. Uses wplm_pkg.
module wplm_front #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  wplm_pkg::cfg_t         cfg,
  input  logic                   in_valid,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   in_ready,
  input  logic                   queue_full,
  output logic                   push,
  output logic [SAMPLE_BITS-1:0] push_peak
);

  logic [wplm_pkg::WLEN_BITS-1:0] sample_index;
  logic [SAMPLE_BITS-1:0]         window_peak;
  logic [wplm_pkg::WLEN_BITS-1:0] eff_len;
  logic [wplm_pkg::WLEN_BITS:0]   index_inc;
  logic                           win_end;
  logic [SAMPLE_BITS-1:0]         peak_next;
  logic                           accept;

  // A zero length acts as one sample per window
  assign eff_len   = (cfg.window_length == '0) ? wplm_pkg::WLEN_BITS'(1) : cfg.window_length;
  assign index_inc = {1'b0, sample_index} + (wplm_pkg::WLEN_BITS+1)'(1);
  assign win_end   = index_inc >= {1'b0, eff_len};
  assign peak_next = (sample > window_peak) ? sample : window_peak;

  // Stall only when a window end has no room in the queue
  assign in_ready  = !win_end || !queue_full;
  assign accept    = in_valid && in_ready;
  assign push      = accept && win_end;
  assign push_peak = peak_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      window_peak  <= '0;
    end else if (accept) begin
      if (win_end) begin
        sample_index <= '0;
        window_peak  <= '0;
      end else begin
        sample_index <= index_inc[wplm_pkg::WLEN_BITS-1:0];
        window_peak  <= peak_next;
      end
    end
  end

endmodule

// ===== hdl/wplm_queue.sv =====
// Short FIFO of window peaks between front and back end.
// Depth from wplm_pkg::QUEUE_DEPTH.
module wplm_queue #(
  parameter int WIDTH = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);

  localparam int DEPTH    = wplm_pkg::QUEUE_DEPTH;
  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    entries [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] fill;
  logic                do_push;
  logic                do_pop;

  assign full      = fill == CNT_BITS'(DEPTH);
  assign not_empty = fill != '0;
  assign head      = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_BITS'(1);
      end
    end
  end

endmodule

// ===== hdl/wplm_back.sv =====
// Back end: sums window peaks, drops the window after each set and runs the
// level check. Holds the output register. Uses wplm_pkg.
module wplm_back #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  wplm_pkg::cfg_t                  cfg,
  input  logic                            peak_valid,
  input  logic [SAMPLE_BITS-1:0]          peak,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output wplm_pkg::status_t               status,
  output logic [wplm_pkg::SUM_BITS-1:0]   peak_total
);

  localparam int SB = wplm_pkg::SUM_BITS;

  logic [wplm_pkg::WCOUNT_BITS-1:0] window_index;
  logic [SB-1:0]                    peak_sum;
  logic [wplm_pkg::WCOUNT_BITS-1:0] cnt;
  logic                             check;
  logic                             slot_free;
  logic [SB-1:0]                    dis_thr;
  logic [SB-1:0]                    intr_thr;
  logic [SB:0]                      sum_add;
  logic [SB-1:0]                    sum_next;
  wplm_pkg::status_t                status_next;

  assign cnt       = (cfg.windows_per_check == '0) ? wplm_pkg::WCOUNT_BITS'(1)
                                                   : cfg.windows_per_check;
  assign check     = window_index >= cnt;
  assign slot_free = !out_valid || out_ready;
  assign pop       = peak_valid && (!check || slot_free);

  // Mean below level <=> sum below level * count
  assign dis_thr  = SB'(cfg.disconnect_level) * SB'(cnt);
  assign intr_thr = SB'(cfg.intruder_level) * SB'(cnt);

  assign sum_add  = {1'b0, peak_sum} + (SB+1)'(peak);
  assign sum_next = sum_add[SB] ? wplm_pkg::SUM_MAX : sum_add[SB-1:0];

  always_comb begin
    if (peak_sum < dis_thr) begin
      status_next = wplm_pkg::STATUS_DISCONNECTED;
    end else if (peak_sum < intr_thr) begin
      status_next = wplm_pkg::STATUS_INTRUDER;
    end else begin
      status_next = wplm_pkg::STATUS_FINE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_index <= '0;
      peak_sum     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (pop && check) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (check) begin
          // This window is the discarded one: drop its peak
          window_index <= '0;
          peak_sum     <= '0;
        end else begin
          window_index <= window_index + wplm_pkg::WCOUNT_BITS'(1);
          peak_sum     <= sum_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && check) begin
      status     <= status_next;
      peak_total <= peak_sum;
    end
  end

endmodule

// ===== hdl/window_peak_level_monitor_top.sv =====
// Window peak level monitor: top level with configuration registers.
// Instantiates wplm_front, wplm_queue and wplm_back; uses wplm_pkg.
//
// Usage:
//   s_* carries one converter sample per transaction (s_tdata bits
//   [SAMPLE_BITS-1:0]). Each window of window_length samples yields a peak;
//   windows_per_check peaks are summed, the next window is dropped, and its
//   last sample produces one m_* transaction with the status and the sum.
//   cfg_* writes a register by index (0 intruder level, 1 disconnect level,
//   2 window length, 3 windows per check); cfg_ready is always high.
//   Throughput: one sample per cycle. The front end stalls only when a
//   window ends while the four-entry peak queue is full.
//   The peak that ends the dropped window passes through the queue and then
//   the back end, which registers m_tvalid; it waits if earlier peaks queue.
//   The check itself is two 12x8 multiplies and compares in the back end.
//   When m_tready is low the result is held in the output register; the
//   back end keeps summing peaks and waits only at the next check, after
//   which the queue fills and s_tready drops at a window end.
//   Reset clears counters, peak, sum, queue and output valid, and loads the
//   register defaults (4000, 1000, 30000, 100).
module window_peak_level_monitor_top #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  input  logic [8*((SAMPLE_BITS+7)/8)-1:0]           s_tdata,   // sample
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  output logic [wplm_pkg::OUT_TDATA_BITS-1:0]        m_tdata,   // status, peak_total
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [wplm_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
  input  logic [wplm_pkg::CFG_DATA_BITS-1:0]         cfg_data
);

  wplm_pkg::cfg_t                   cfg;
  logic                             queue_full;
  logic                             queue_valid;
  logic                             push;
  logic                             pop;
  logic [SAMPLE_BITS-1:0]           push_peak;
  logic [SAMPLE_BITS-1:0]           head_peak;
  wplm_pkg::status_t                status;
  logic [wplm_pkg::SUM_BITS-1:0]    peak_total;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.intruder_level    <= wplm_pkg::RST_INTRUDER_LEVEL;
      cfg.disconnect_level  <= wplm_pkg::RST_DISCONNECT_LEVEL;
      cfg.window_length     <= wplm_pkg::RST_WINDOW_LENGTH;
      cfg.windows_per_check <= wplm_pkg::RST_WINDOWS_PER_CHECK;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        wplm_pkg::CFG_INTRUDER_LEVEL: begin
          cfg.intruder_level <= cfg_data[wplm_pkg::LEVEL_BITS-1:0];
        end
        wplm_pkg::CFG_DISCONNECT_LEVEL: begin
          cfg.disconnect_level <= cfg_data[wplm_pkg::LEVEL_BITS-1:0];
        end
        wplm_pkg::CFG_WINDOW_LENGTH: begin
          cfg.window_length <= cfg_data[wplm_pkg::WLEN_BITS-1:0];
        end
        wplm_pkg::CFG_WINDOWS_PER_CHECK: begin
          cfg.windows_per_check <= cfg_data[wplm_pkg::WCOUNT_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  wplm_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .sample     (s_tdata[SAMPLE_BITS-1:0]),
    .in_ready   (s_tready),
    .queue_full (queue_full),
    .push       (push),
    .push_peak  (push_peak)
  );

  wplm_queue #(
    .WIDTH(SAMPLE_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_peak),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_valid),
    .head      (head_peak)
  );

  wplm_back #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .peak_valid (queue_valid),
    .peak       (head_peak),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .status     (status),
    .peak_total (peak_total)
  );

  assign m_tdata = {
    (wplm_pkg::OUT_TDATA_BITS - wplm_pkg::SUM_BITS - wplm_pkg::STATUS_BITS)'(0),
    peak_total,
    status
  };

endmodule
